@@ src/swhsr_pkg.sv @@
// ----------------------------------------------------------------------------
// swhsr_pkg: shared types and constants for the single-wire sensor reader
// Holds the read phase type, configuration bundle, result bundle and the
// register index codes used by the configuration port.
// ----------------------------------------------------------------------------
package swhsr_pkg;

    localparam int FRAME_BITS       = 40;
    localparam int BIT_CNT_W        = 6;
    localparam int EDGE_W           = 7;
    localparam int EDGE_LIMIT_DEF   = 85;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;

    localparam logic [7:0]  THRESHOLD_RST = 8'd50;
    localparam logic [7:0]  TIMEOUT_RST   = 8'd255;
    localparam logic [15:0] START_LOW_RST = 16'd20000;
    localparam logic [7:0]  RELEASE_RST   = 8'd40;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2,
        PH_READ = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENSOR_MODEL    = 3'd0,
        REG_BIT_THRESHOLD   = 3'd1,
        REG_TIMEOUT_TICKS   = 3'd2,
        REG_START_LOW_TICKS = 3'd3,
        REG_RELEASE_TICKS   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic        sensor_model;
        logic [7:0]  bit_threshold;
        logic [7:0]  timeout_ticks;
        logic [15:0] start_low_ticks;
        logic [7:0]  release_ticks;
    } cfg_t;

    typedef struct packed {
        logic               drive_enable;
        logic               drive_level;
        logic               busy_res;
        logic               done_res;
        logic               read_ok;
        logic signed [15:0] humidity_out;
        logic signed [15:0] temperature_out;
    } result_t;

endpackage

@@ src/swhsr_cfg.sv @@
// ----------------------------------------------------------------------------
// swhsr_cfg: configuration register file
// Takes one register write per cycle and presents the settings as a bundle.
// ----------------------------------------------------------------------------
module swhsr_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [swhsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swhsr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output swhsr_pkg::cfg_t                      cfg
);

    swhsr_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_model    <= 1'b0;
            cfg_reg.bit_threshold   <= swhsr_pkg::THRESHOLD_RST;
            cfg_reg.timeout_ticks   <= swhsr_pkg::TIMEOUT_RST;
            cfg_reg.start_low_ticks <= swhsr_pkg::START_LOW_RST;
            cfg_reg.release_ticks   <= swhsr_pkg::RELEASE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // indexes past the list are dropped
            unique case (cfg_index)
                swhsr_pkg::REG_SENSOR_MODEL:    cfg_reg.sensor_model    <= cfg_data[0];
                swhsr_pkg::REG_BIT_THRESHOLD:   cfg_reg.bit_threshold   <= cfg_data[7:0];
                swhsr_pkg::REG_TIMEOUT_TICKS:   cfg_reg.timeout_ticks   <= cfg_data[7:0];
                swhsr_pkg::REG_START_LOW_TICKS: cfg_reg.start_low_ticks <= cfg_data;
                swhsr_pkg::REG_RELEASE_TICKS:   cfg_reg.release_ticks   <= cfg_data[7:0];
                default:                        ;
            endcase
        end
    end

endmodule

@@ src/swhsr_core.sv @@
// ----------------------------------------------------------------------------
// swhsr_core: read sequencer and frame decoder
// Holds the read state, advances it by one item per fire and forms the
// result for that item from the updated state.
// ----------------------------------------------------------------------------
module swhsr_core
#(
    parameter int EDGE_LIMIT = swhsr_pkg::EDGE_LIMIT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic                 command,
    input  logic                 pin_level,
    input  swhsr_pkg::cfg_t      cfg,
    output swhsr_pkg::result_t   result
);

    localparam logic [swhsr_pkg::EDGE_W-1:0] EDGE_LIM = swhsr_pkg::EDGE_W'(EDGE_LIMIT);
    localparam logic [swhsr_pkg::BIT_CNT_W-1:0] FRAME_CNT =
        swhsr_pkg::BIT_CNT_W'(swhsr_pkg::FRAME_BITS);

    swhsr_pkg::phase_t                   phase_reg,      phase_next;
    logic [15:0]                         phase_ticks_reg, phase_ticks_next;
    logic [7:0]                          run_ticks_reg,  run_ticks_next;
    logic                                last_level_reg, last_level_next;
    logic [swhsr_pkg::EDGE_W-1:0]        edge_index_reg, edge_index_next;
    logic [swhsr_pkg::BIT_CNT_W-1:0]     bit_count_reg,  bit_count_next;
    logic [swhsr_pkg::FRAME_BITS-1:0]    shift_bits_reg, shift_bits_next;
    logic [15:0]                         humidity_reg,   humidity_next;
    logic [15:0]                         temperature_reg, temperature_next;
    logic                                done, ok;

    logic [7:0]  limit;
    logic [15:0] phase_inc;
    logic [7:0]  run_inc;
    logic [swhsr_pkg::EDGE_W-1:0] edge_inc;
    logic [7:0]  b0, b1, b2, b3, b4;
    logic [15:0] raw_t;
    logic        frame_good;

    assign limit     = (cfg.timeout_ticks == 8'd0) ? 8'd1 : cfg.timeout_ticks;
    assign phase_inc = phase_ticks_reg + 16'd1;
    assign run_inc   = run_ticks_reg + 8'd1;
    assign edge_inc  = edge_index_reg + swhsr_pkg::EDGE_W'(1);

    // frame fields come from the post-update shift register
    assign b0 = shift_bits_next[39:32];
    assign b1 = shift_bits_next[31:24];
    assign b2 = shift_bits_next[23:16];
    assign b3 = shift_bits_next[15:8];
    assign b4 = shift_bits_next[7:0];
    assign raw_t = {b2, b3};
    assign frame_good = (bit_count_next >= FRAME_CNT) && (8'(b0 + b1 + b2 + b3) == b4);

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        phase_ticks_next = phase_ticks_reg;
        run_ticks_next   = run_ticks_reg;
        last_level_next  = last_level_reg;
        edge_index_next  = edge_index_reg;
        bit_count_next   = bit_count_reg;
        shift_bits_next  = shift_bits_reg;
        done             = 1'b0;

        if (command)
        begin
            phase_next       = swhsr_pkg::PH_LOW;
            phase_ticks_next = 16'd0;
        end
        else
        begin
            unique case (phase_reg)
                swhsr_pkg::PH_IDLE: ;
                swhsr_pkg::PH_LOW:
                begin
                    phase_ticks_next = phase_inc;
                    if (phase_inc >= cfg.start_low_ticks || phase_inc == 16'd0)
                    begin
                        phase_ticks_next = 16'd0;
                        phase_next = (cfg.release_ticks == 8'd0) ? swhsr_pkg::PH_READ
                                                                 : swhsr_pkg::PH_HIGH;
                    end
                end
                swhsr_pkg::PH_HIGH:
                begin
                    phase_ticks_next = phase_inc;
                    if (phase_inc >= {8'd0, cfg.release_ticks})
                    begin
                        phase_next       = swhsr_pkg::PH_READ;
                        phase_ticks_next = 16'd0;
                    end
                end
                swhsr_pkg::PH_READ:
                begin
                    if (pin_level == last_level_reg)
                    begin
                        run_ticks_next = run_inc;
                        done = (run_inc >= limit);
                    end
                    else
                    begin
                        // edges with an even index from four on close a data bit until the frame is full
                        if (edge_index_reg >= swhsr_pkg::EDGE_W'(4) && !edge_index_reg[0]
                            && bit_count_reg < FRAME_CNT)
                        begin
                            shift_bits_next = {shift_bits_reg[swhsr_pkg::FRAME_BITS-2:0],
                                               (run_ticks_reg > cfg.bit_threshold)};
                            bit_count_next  = bit_count_reg + swhsr_pkg::BIT_CNT_W'(1);
                        end
                        last_level_next = pin_level;
                        edge_index_next = edge_inc;
                        run_ticks_next  = 8'd1;
                        done = (edge_inc >= EDGE_LIM) || (limit == 8'd1);
                    end
                    if (done)
                    begin
                        phase_next       = swhsr_pkg::PH_IDLE;
                        phase_ticks_next = 16'd0;
                    end
                end
                default: ;
            endcase
        end

        // entering the read phase clears the frame collection
        if (phase_next == swhsr_pkg::PH_READ && phase_reg != swhsr_pkg::PH_READ)
        begin
            run_ticks_next  = 8'd0;
            last_level_next = 1'b1;
            edge_index_next = '0;
            bit_count_next  = '0;
            shift_bits_next = '0;
        end
    end

    // decode and result
    always_comb
    begin
        ok               = done && frame_good;
        humidity_next    = humidity_reg;
        temperature_next = temperature_reg;
        if (ok)
        begin
            if (!cfg.sensor_model)
            begin
                humidity_next    = {8'd0, b0};
                temperature_next = {8'd0, b2};
            end
            else
            begin
                humidity_next    = {b0, b1};
                temperature_next = raw_t[15] ? (16'd0 - {1'b0, raw_t[14:0]}) : raw_t;
            end
        end

        result.drive_enable    = (phase_next == swhsr_pkg::PH_LOW)
                              || (phase_next == swhsr_pkg::PH_HIGH);
        result.drive_level     = (phase_next == swhsr_pkg::PH_HIGH);
        result.busy_res        = (phase_next != swhsr_pkg::PH_IDLE);
        result.done_res        = done;
        result.read_ok         = ok;
        result.humidity_out    = signed'(humidity_next);
        result.temperature_out = signed'(temperature_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= swhsr_pkg::PH_IDLE;
            phase_ticks_reg <= 16'd0;
            run_ticks_reg   <= 8'd0;
            last_level_reg  <= 1'b1;
            edge_index_reg  <= '0;
            bit_count_reg   <= '0;
            shift_bits_reg  <= '0;
            humidity_reg    <= 16'd0;
            temperature_reg <= 16'd0;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            phase_ticks_reg <= phase_ticks_next;
            run_ticks_reg   <= run_ticks_next;
            last_level_reg  <= last_level_next;
            edge_index_reg  <= edge_index_next;
            bit_count_reg   <= bit_count_next;
            shift_bits_reg  <= shift_bits_next;
            humidity_reg    <= humidity_next;
            temperature_reg <= temperature_next;
        end
    end

endmodule

@@ src/single_wire_humidity_sensor_reader.sv @@
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader: one-wire temperature/humidity reader
// Per-tick sequencer that starts a sensor read, times line runs and decodes
// the 40-bit frame into humidity and temperature.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, command, pin_level): send one
//   transaction per microsecond tick with the sampled line, or a start
//   command. Output channel (out_valid / out_stall): exactly one result
//   transaction per input transaction, showing line drive, busy, done,
//   read_ok and the last good humidity and temperature.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data):
//   always ready; write only while no transaction is in flight.
//   Path: a transaction is captured in the input register when accepted,
//   processed combinationally by the sequencer and loaded into the result
//   register when it advances; out_stall can hold it in the input register.
//   Throughput: one transaction per cycle while out_stall is low; the
//   sequencer state between input and result registers updates on advance.
//   Stall: while out_stall holds a result, the input register fills and
//   in_stall rises; nothing is dropped and no state moves.
//   Reset: the read phase goes idle, held readings clear to zero and the
//   registers return to their defaults.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader
#(
    parameter int EDGE_LIMIT = swhsr_pkg::EDGE_LIMIT_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              command,
    input  logic                              pin_level,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              drive_enable,
    output logic                              drive_level,
    output logic                              busy_res,
    output logic                              done_res,
    output logic                              read_ok,
    output logic signed [15:0]                humidity_out,
    output logic signed [15:0]                temperature_out,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swhsr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swhsr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    swhsr_pkg::cfg_t    cfg;
    swhsr_pkg::result_t core_result;
    swhsr_pkg::result_t res_reg;

    logic in_full_reg;
    logic in_cmd_reg;
    logic in_pin_reg;
    logic out_valid_reg;
    logic accept;
    logic advance;

    // advance the held transaction whenever the result slot is free or draining
    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;
    assign accept   = in_valid && !in_stall;

    swhsr_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swhsr_core #(.EDGE_LIMIT(EDGE_LIMIT)) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .command   (in_cmd_reg),
        .pin_level (in_pin_reg),
        .cfg       (cfg),
        .result    (core_result)
    );

    // input register: hold the transaction until the sequencer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_cmd_reg <= command;
            in_pin_reg <= pin_level;
        end
    end

    // result register: load on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= core_result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign drive_enable    = res_reg.drive_enable;
    assign drive_level     = res_reg.drive_level;
    assign busy_res        = res_reg.busy_res;
    assign done_res        = res_reg.done_res;
    assign read_ok         = res_reg.read_ok;
    assign humidity_out    = res_reg.humidity_out;
    assign temperature_out = res_reg.temperature_out;

    // a finished read leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.done_res |-> !res_reg.busy_res)
        else $error("done result reports busy");

    // success is only reported with done
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.read_ok |-> res_reg.done_res)
        else $error("read_ok without done");

    // the line is driven high only while drive is enabled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.drive_level |-> res_reg.drive_enable)
        else $error("drive level without drive enable");

    // stall only when a held transaction meets a blocked result slot
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_full_reg && out_valid_reg && out_stall))
        else $error("input stalled with room downstream");

endmodule

@@ test/swhsr_checker.sv @@
// ----------------------------------------------------------------------------
// swhsr_checker: result predictor and scoreboard for the sensor reader
// Watches the input, result and configuration channels, predicts one result
// per accepted transaction and compares it field by field with the block.
// ----------------------------------------------------------------------------
module swhsr_checker
    import swhsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  command,
    input  logic                  pin_level,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  drive_enable,
    input  logic                  drive_level,
    input  logic                  busy_res,
    input  logic                  done_res,
    input  logic                  read_ok,
    input  logic signed [15:0]    humidity_out,
    input  logic signed [15:0]    temperature_out,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    pending,
    output int                    fail_count
);

    cfg_t                  mirror_cfg;
    phase_t                rd_phase;
    logic [15:0]           phase_cnt;
    logic [7:0]            run_len;
    logic                  line_level;
    logic [EDGE_W-1:0]     edge_cnt;
    logic [BIT_CNT_W-1:0]  bits_seen;
    logic [FRAME_BITS-1:0] frame_bits;
    logic [15:0]           held_hum;
    logic [15:0]           held_temp;
    result_t               expected_readouts[$];
    int                    mismatches = 0;

    initial pending = 0;
    initial fail_count = 0;

    task automatic open_frame();
        rd_phase   = PH_READ;
        phase_cnt  = '0;
        run_len    = '0;
        line_level = 1'b1;
        edge_cnt   = '0;
        bits_seen  = '0;
        frame_bits = '0;
    endtask

    // Close the read, verify the byte sum and latch the decoded readings.
    task automatic close_frame(output logic good);
        logic [7:0]  b0, b1, b2, b3, b4, sum;
        logic [15:0] t_word;
        {b0, b1, b2, b3, b4} = frame_bits;
        sum       = b0 + b1 + b2 + b3;
        good      = (bits_seen >= FRAME_BITS) && (sum == b4);
        rd_phase  = PH_IDLE;
        phase_cnt = '0;
        if (good)
        begin
            if (!mirror_cfg.sensor_model)
            begin
                held_hum  = {8'd0, b0};
                held_temp = {8'd0, b2};
            end
            else
            begin
                held_hum  = {b0, b1};
                t_word    = {b2, b3};
                // sign-magnitude: bit 15 is the sign, negative zero folds to zero
                held_temp = t_word[15] ? 16'd0 - {1'b0, t_word[14:0]} : t_word;
            end
        end
    endtask

    task automatic step_reader(input logic cmd, input logic pin, output result_t r);
        logic [7:0] lim;
        logic       fin;
        logic       good;
        lim  = (mirror_cfg.timeout_ticks == 8'd0) ? 8'd1 : mirror_cfg.timeout_ticks;
        fin  = 1'b0;
        good = 1'b0;
        if (cmd)
        begin
            rd_phase  = PH_LOW;
            phase_cnt = '0;
        end
        else
        begin
            case (rd_phase)
                PH_LOW:
                begin
                    phase_cnt = phase_cnt + 16'd1;
                    if (phase_cnt >= mirror_cfg.start_low_ticks || phase_cnt == 16'd0)
                    begin
                        phase_cnt = '0;
                        if (mirror_cfg.release_ticks == 8'd0)
                            open_frame();
                        else
                            rd_phase = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    phase_cnt = phase_cnt + 16'd1;
                    if (phase_cnt >= {8'd0, mirror_cfg.release_ticks})
                        open_frame();
                end
                PH_READ:
                begin
                    if (pin == line_level)
                    begin
                        run_len = run_len + 8'd1;
                        fin     = (run_len >= lim);
                    end
                    else
                    begin
                        // every second change from the fifth on ends a bit's high run
                        if (edge_cnt >= 4 && !edge_cnt[0] && bits_seen < FRAME_BITS)
                        begin
                            frame_bits = {frame_bits[FRAME_BITS-2:0],
                                          run_len > mirror_cfg.bit_threshold};
                            bits_seen  = bits_seen + 1'b1;
                        end
                        line_level = pin;
                        edge_cnt   = edge_cnt + 1'b1;
                        run_len    = 8'd1;
                        fin        = (edge_cnt >= EDGE_LIMIT_DEF) || (run_len >= lim);
                    end
                    if (fin)
                        close_frame(good);
                end
                default: ;
            endcase
        end
        r.drive_enable    = (rd_phase == PH_LOW) || (rd_phase == PH_HIGH);
        r.drive_level     = (rd_phase == PH_HIGH);
        r.busy_res        = (rd_phase != PH_IDLE);
        r.done_res        = fin;
        r.read_ok         = good;
        r.humidity_out    = held_hum;
        r.temperature_out = held_temp;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        result_t predicted;
        result_t want;
        if (!rst_n)
        begin
            mirror_cfg = '{1'b0, THRESHOLD_RST, TIMEOUT_RST, START_LOW_RST, RELEASE_RST};
            open_frame();
            rd_phase  = PH_IDLE;
            held_hum  = '0;
            held_temp = '0;
            expected_readouts.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_SENSOR_MODEL:    mirror_cfg.sensor_model    = cfg_data[0];
                    REG_BIT_THRESHOLD:   mirror_cfg.bit_threshold   = cfg_data[7:0];
                    REG_TIMEOUT_TICKS:   mirror_cfg.timeout_ticks   = cfg_data[7:0];
                    REG_START_LOW_TICKS: mirror_cfg.start_low_ticks = cfg_data;
                    REG_RELEASE_TICKS:   mirror_cfg.release_ticks   = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_readouts.size() == 0)
                begin
                    $error("result transaction with no prediction pending");
                    mismatches++;
                end
                else
                begin
                    want = expected_readouts.pop_front();
                    check_field("drive_enable", want.drive_enable, drive_enable);
                    check_field("drive_level", want.drive_level, drive_level);
                    check_field("busy_res", want.busy_res, busy_res);
                    check_field("done_res", want.done_res, done_res);
                    check_field("read_ok", want.read_ok, read_ok);
                    check_field("humidity_out", want.humidity_out, humidity_out);
                    check_field("temperature_out", want.temperature_out, temperature_out);
                end
            end
            if (in_valid && !in_stall)
            begin
                step_reader(command, pin_level, predicted);
                expected_readouts.push_back(predicted);
            end
            pending <= expected_readouts.size();
        end
        fail_count <= mismatches;
    end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the single-wire sensor reader
// Plays a sensor on the data line: start commands, drive-phase ticks and
// timed level runs that encode 40-bit frames, plus noise and broken frames,
// across several register settings and idling mixes. A checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import swhsr_pkg::*;

    // Cycles with no transaction on any channel before the run is declared hung.
    // Stall streaks at the heaviest idling are far shorter than this.
    localparam int QUIET_LIMIT = 3000;

    typedef enum int {
        RK_GOOD,
        RK_BAD_SUM,
        RK_SHORT,
        RK_EXTRA,
        RK_CUT,
        RK_QUIET
    } read_kind_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  command = 1'b0;
    logic                  pin_level = 1'b1;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  drive_enable;
    logic                  drive_level;
    logic                  busy_res;
    logic                  done_res;
    logic                  read_ok;
    logic signed [15:0]    humidity_out;
    logic signed [15:0]    temperature_out;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    pending;
    int                    fail_count;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   quiet_cycles = 0;
    cfg_t cur;
    logic line_lvl = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    single_wire_humidity_sensor_reader DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .pin_level       (pin_level),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .drive_enable    (drive_enable),
        .drive_level     (drive_level),
        .busy_res        (busy_res),
        .done_res        (done_res),
        .read_ok         (read_ok),
        .humidity_out    (humidity_out),
        .temperature_out (temperature_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    swhsr_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .pin_level       (pin_level),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .drive_enable    (drive_enable),
        .drive_level     (drive_level),
        .busy_res        (busy_res),
        .done_res        (done_res),
        .read_ok         (read_ok),
        .humidity_out    (humidity_out),
        .temperature_out (temperature_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pending         (pending),
        .fail_count      (fail_count)
    );

    // Receiver stalls at the current rate.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Watchdog: end the run if no channel moves a transaction for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int min2(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    // Present one transaction, idling first at the sender's rate; hold the
    // payload until the block takes it. Valid stays high for a following item.
    task automatic send_item(input logic cmd, input logic pin);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        pin_level <= pin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_regs(input cfg_t s);
        write_reg(REG_SENSOR_MODEL, {15'd0, s.sensor_model});
        write_reg(REG_BIT_THRESHOLD, {8'd0, s.bit_threshold});
        write_reg(REG_TIMEOUT_TICKS, {8'd0, s.timeout_ticks});
        write_reg(REG_START_LOW_TICKS, s.start_low_ticks);
        write_reg(REG_RELEASE_TICKS, {8'd0, s.release_ticks});
        cfg_valid <= 1'b0;
        cur = s;
    endtask

    // Drop valid, wait for every predicted result, then let the pipeline
    // run on idle so no transaction is still inside the block.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic hold_line(input int n);
        repeat (n) send_item(1'b0, line_lvl);
    endtask

    // Flip the line; the first tick at the new level is the first of the run.
    task automatic toggle_run(input int len);
        line_lvl = !line_lvl;
        hold_line(len);
    endtask

    function automatic int short_run(input int lim);
        return $urandom_range(1, min2(3, lim - 1));
    endfunction

    // High-run length that encodes the wanted bit, where the threshold and
    // timeout allow it; boundary lengths are chosen now and then.
    function automatic int bit_run(input logic b, input int lim);
        int thr;
        int hi;
        thr = int'(cur.bit_threshold);
        hi  = lim - 1;
        if (b && thr < hi)
            return $urandom_range(thr + 1, min2(thr + 2, hi));
        if (!b && thr >= 1)
        begin
            if (min2(thr, hi) <= 8 && $urandom_range(0, 3) == 0)
                return min2(thr, hi);
            return $urandom_range(1, min2(3, min2(thr, hi)));
        end
        return $urandom_range(1, min2(3, hi));
    endfunction

    // One sensor read: start, drive-phase ticks with random line samples,
    // then the sensor's reply as timed level runs, ended as the kind asks.
    task automatic sensor_read(input read_kind_t kind);
        logic [39:0] frame;
        logic [7:0]  hum_hi, hum_lo, tmp_hi, tmp_lo, check;
        int          lim;
        int          lead;
        int          nbits;
        lim  = (cur.timeout_ticks == 8'd0) ? 1 : int'(cur.timeout_ticks);
        lead = (cur.start_low_ticks == 16'd0) ? 1 : int'(cur.start_low_ticks);
        lead = lead + int'(cur.release_ticks);
        send_item(1'b1, 1'($urandom));
        repeat (lead) send_item(1'b0, 1'($urandom));
        if (lim < 2)
        begin
            // every tick ends the read at once; the rest fall on an idle block
            repeat ($urandom_range(1, 3)) send_item(1'b0, 1'($urandom));
            return;
        end
        line_lvl = 1'b1;
        if (kind == RK_QUIET)
        begin
            hold_line(lim);
            return;
        end
        hold_line($urandom_range(0, min2(2, lim - 1)));
        toggle_run(short_run(lim));
        toggle_run(short_run(lim));
        hum_hi = 8'($urandom);
        hum_lo = 8'($urandom);
        tmp_hi = 8'($urandom);
        tmp_lo = 8'($urandom);
        if (cur.sensor_model && $urandom_range(0, 7) == 0)
        begin
            // negative zero temperature
            tmp_hi = 8'h80;
            tmp_lo = 8'h00;
        end
        check = hum_hi + hum_lo + tmp_hi + tmp_lo;
        if (kind == RK_BAD_SUM)
            check = check ^ (8'd1 << $urandom_range(0, 7));
        frame = {hum_hi, hum_lo, tmp_hi, tmp_lo, check};
        nbits = (kind == RK_SHORT || kind == RK_CUT) ? $urandom_range(0, 39) : 40;
        for (int i = 0; i < nbits; i++)
        begin
            toggle_run(short_run(lim));
            toggle_run(bit_run(frame[39 - i], lim));
        end
        // a cut frame is abandoned mid-stream; the next start drops it
        if (kind == RK_CUT)
            return;
        toggle_run(short_run(lim));
        case (kind)
            RK_SHORT: hold_line(lim);
            RK_EXTRA:
            begin
                // one more change past the frame hits the edge limit
                toggle_run(short_run(lim));
                toggle_run(1);
            end
            default: toggle_run(lim);
        endcase
    endtask

    task automatic run_phase(input cfg_t s, input int frames, input int noise_items);
        read_kind_t kind;
        program_regs(s);
        if (noise_items > 0)
        begin
            repeat (noise_items)
                send_item($urandom_range(0, 15) == 0, 1'($urandom));
            sensor_read(RK_QUIET);
        end
        for (int i = 0; i < frames; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: kind = RK_GOOD;
                4, 5:       kind = RK_BAD_SUM;
                6:          kind = RK_SHORT;
                7, 8:       kind = RK_EXTRA;
                default:    kind = RK_CUT;
            endcase
            // leave the block idle at the end of the phase
            if (i == frames - 1 && kind == RK_CUT)
                kind = RK_GOOD;
            sensor_read(kind);
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 28;
        recv_idle_pct = 87;

        // Keep reset thresholds and timeout; shorten only the drive phases.
        write_reg(REG_START_LOW_TICKS, 16'd3);
        write_reg(REG_RELEASE_TICKS, 16'd2);
        cfg_valid <= 1'b0;
        cur = '{1'b0, THRESHOLD_RST, TIMEOUT_RST, 16'd3, 8'd2};

        // Directed: idle ticks, restart in the low phase, pin ignored while
        // driving, and a start that drops a read in progress.
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b1);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b0);
        send_item(1'b1, 1'b0);
        // a steady line runs into the full default timeout
        sensor_read(RK_QUIET);
        wait_drained();

        run_phase('{1'b1, 8'd1, 8'd3, 16'd1, 8'd1}, 2, 10);

        send_idle_pct = 87;
        recv_idle_pct = 28;
        run_phase('{1'b1, 8'd0, 8'd4, 16'd2, 8'd255}, 1, 0);
        run_phase('{1'b1, 8'd3, 8'd1, 16'd2, 8'd0}, 6, 10);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase('{1'b0, 8'd1, 8'd0, 16'd1, 8'd1}, 6, 10);
        run_phase('{1'b0, 8'd2, 8'd6, 16'd0, 8'd0}, 1, 10);

        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
src/swhsr_pkg.sv
src/swhsr_cfg.sv
src/swhsr_core.sv
src/single_wire_humidity_sensor_reader.sv
test/swhsr_checker.sv
test/tb_top.sv
